### rtl/tkp_pkg.sv
`timescale 1ns / 1ps

package tkp_pkg;

   localparam int SLOTS_DEF = 32;
   localparam int MAX_OUT = 32;
   localparam int TOTAL_W = $clog2(MAX_OUT + 1);
   localparam int KEY_W = 25;

   typedef enum logic [1:0] {
      REQ_RECORD = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_DUMP   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      OUT_ACCUM   = 3'd0,
      OUT_INSERT  = 3'd1,
      OUT_REPLACE = 3'd2,
      OUT_DROP    = 3'd3,
      OUT_IGNORE  = 3'd4,
      OUT_CTL     = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_COUNT,
      ST_DUMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [31:0]      line;
      logic [31:0]      calls;
      logic [63:0]      cycles;
   } slot_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] start_cycles;
      logic [31:0] end_cycles;
      logic [7:0]  phase_id;
      logic [31:0] group_id;
      logic [31:0] source_line;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic        entry_valid;
      logic        entry_probe;
      logic [7:0]  entry_phase;
      logic [15:0] entry_group;
      logic [31:0] entry_line;
      logic [31:0] entry_calls;
      logic [63:0] entry_cycles;
      logic        last;
   } rsp_payload_type;

endpackage

### rtl/top_k_interval_profile_table_core.sv
`timescale 1ns / 1ps

// Profile table of SLOTS entries keyed by probe bit, phase and group.
// Requests enter on req_valid/req_stall with a req_payload struct; results leave on
// rsp_valid/rsp_stall with a rsp_payload struct. The csr port writes enable (index 0)
// and probe_flag (index 1); writing only while the block is idle is up to the user.
// The slots sit in a ring of cells that rotates one place per cycle while shifted, and
// the control looks at the head cell only. A record request rotates the ring once to
// find the matching, empty or smallest slot and, unless it is dropped, once more to
// write it back before its single result is offered. A clear request or an ignored
// record goes straight to its result. A dump request counts occupied slots in one pass
// and emits up to 32 of them in the next pass, with a single result instead if none
// is occupied; the receiver's stalls pause it. One request is in the block at a time;
// req_stall is high until the block is idle again, after the final result is loaded or
// the dump pass ends; the next request can then be taken.
// Reset empties every slot and clears enable and probe_flag.
// While rsp_stall is high the output register holds its result; a dump then pauses
// the ring until the result is taken.

module top_k_interval_profile_table_core #(
   parameter int SLOTS = tkp_pkg::SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tkp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tkp_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic                     csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TW = tkp_pkg::TOTAL_W;

   tkp_pkg::slot_type ring_q [SLOTS];
   tkp_pkg::slot_type head;
   tkp_pkg::slot_type tail_in;
   tkp_pkg::slot_type upd_slot;

   tkp_pkg::state_type state_ff, state_in;
   logic [IW-1:0]             pos_ff, hit_ff, min_pos_ff;
   logic                      found_ff, ins_ff;
   logic [63:0]               min_cyc_ff;
   logic [31:0]               elapsed_ff, line_ff;
   logic [tkp_pkg::KEY_W-1:0] key_ff;
   tkp_pkg::outcome_type      outcome_ff;
   logic [CW-1:0]             cnt_ff;
   logic [TW-1:0]             total_ff, sent_ff;
   logic                      enable_ff, probe_ff;
   logic                      rsp_valid_ff;
   tkp_pkg::rsp_payload_type  rsp_ff;

   logic          accept, out_free, at_end, occ, match_now, need_emit;
   logic          shift, clear, load_entry, load_final;
   logic          ignore_rec;
   logic [CW-1:0] cnt_fin;
   logic [TW-1:0] total_fin;
   logic [63:0]   base_cyc;
   logic [31:0]   base_calls;

   assign head      = ring_q[0];
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign at_end    = (pos_ff == IW'(SLOTS - 1));
   assign occ       = (head.calls != '0);
   assign match_now = !occ || (head.key == key_ff);
   assign need_emit = occ && (sent_ff < total_ff);
   assign cnt_fin   = cnt_ff + CW'(occ);
   assign total_fin = (32'(cnt_fin) > 32'(tkp_pkg::MAX_OUT)) ? TW'(tkp_pkg::MAX_OUT)
                                                              : TW'(cnt_fin);
   assign ignore_rec = !enable_ff || (req_payload.start_cycles == '0)
                       || (req_payload.group_id[31:16] != '0);

   assign base_cyc   = ins_ff ? '0 : head.cycles;
   assign base_calls = ins_ff ? '0 : head.calls;
   assign upd_slot   = '{key: key_ff, line: line_ff, calls: base_calls + 32'd1,
                         cycles: base_cyc + {32'd0, elapsed_ff}};
   assign tail_in    = (state_ff == tkp_pkg::ST_UPDATE && pos_ff == hit_ff) ? upd_slot
                                                                           : head;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      tkp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift),
         .clear    (clear),
         .slot_in  ((i == SLOTS - 1) ? tail_in : ring_q[(i + 1) % SLOTS]),
         .slot_out (ring_q[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkp_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_payload.req_type)
                  tkp_pkg::REQ_RECORD: state_in = ignore_rec ? tkp_pkg::ST_RESP
                                                             : tkp_pkg::ST_SCAN;
                  tkp_pkg::REQ_DUMP:   state_in = tkp_pkg::ST_COUNT;
                  default:             state_in = tkp_pkg::ST_RESP;
               endcase
            end
         end
         tkp_pkg::ST_SCAN: begin
            if (at_end) state_in = tkp_pkg::ST_DECIDE;
         end
         tkp_pkg::ST_DECIDE: begin
            state_in = (found_ff || ({32'd0, elapsed_ff} > min_cyc_ff)) ? tkp_pkg::ST_UPDATE
                                                                        : tkp_pkg::ST_RESP;
         end
         tkp_pkg::ST_UPDATE: begin
            if (at_end) state_in = tkp_pkg::ST_RESP;
         end
         tkp_pkg::ST_COUNT: begin
            if (at_end) state_in = (total_fin == '0) ? tkp_pkg::ST_RESP : tkp_pkg::ST_DUMP;
         end
         tkp_pkg::ST_DUMP: begin
            if (at_end && shift) state_in = tkp_pkg::ST_IDLE;
         end
         tkp_pkg::ST_RESP: begin
            if (out_free) state_in = tkp_pkg::ST_IDLE;
         end
         default: state_in = tkp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      shift      = 1'b0;
      clear      = 1'b0;
      load_entry = 1'b0;
      load_final = 1'b0;
      req_stall  = (state_ff != tkp_pkg::ST_IDLE);
      unique case (state_ff)
         tkp_pkg::ST_IDLE: begin
            clear = accept && (req_payload.req_type == tkp_pkg::REQ_CLEAR);
         end
         tkp_pkg::ST_SCAN, tkp_pkg::ST_UPDATE, tkp_pkg::ST_COUNT: begin
            shift = 1'b1;
         end
         tkp_pkg::ST_DUMP: begin
            shift      = !need_emit || out_free;
            load_entry = need_emit && out_free;
         end
         tkp_pkg::ST_RESP: begin
            load_final = out_free;
         end
         default: begin
            shift = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tkp_pkg::ST_IDLE;
         pos_ff    <= '0;
         enable_ff <= 1'b0;
         probe_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (shift) pos_ff <= at_end ? '0 : pos_ff + IW'(1);
         if (csr_we && csr_index == 1'b0) enable_ff <= csr_wdata;
         if (csr_we && csr_index == 1'b1) probe_ff  <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         tkp_pkg::ST_IDLE: begin
            found_ff   <= 1'b0;
            cnt_ff     <= '0;
            sent_ff    <= '0;
            elapsed_ff <= req_payload.end_cycles - req_payload.start_cycles;
            key_ff     <= {probe_ff, req_payload.phase_id, req_payload.group_id[15:0]};
            line_ff    <= req_payload.source_line;
            if (req_payload.req_type == tkp_pkg::REQ_RECORD) begin
               outcome_ff <= tkp_pkg::OUT_IGNORE;
            end else if (req_payload.req_type == tkp_pkg::REQ_NONE) begin
               outcome_ff <= tkp_pkg::OUT_IGNORE;
            end else begin
               outcome_ff <= tkp_pkg::OUT_CTL;
            end
         end
         tkp_pkg::ST_SCAN: begin
            if (!found_ff) begin
               if (match_now) begin
                  found_ff <= 1'b1;
                  hit_ff   <= pos_ff;
                  ins_ff   <= !occ;
               end else if (pos_ff == '0 || head.cycles < min_cyc_ff) begin
                  min_pos_ff <= pos_ff;
                  min_cyc_ff <= head.cycles;
               end
            end
         end
         tkp_pkg::ST_DECIDE: begin
            if (found_ff) begin
               outcome_ff <= ins_ff ? tkp_pkg::OUT_INSERT : tkp_pkg::OUT_ACCUM;
            end else if ({32'd0, elapsed_ff} > min_cyc_ff) begin
               hit_ff     <= min_pos_ff;
               ins_ff     <= 1'b1;
               outcome_ff <= tkp_pkg::OUT_REPLACE;
            end else begin
               outcome_ff <= tkp_pkg::OUT_DROP;
            end
         end
         tkp_pkg::ST_COUNT: begin
            cnt_ff <= cnt_fin;
            if (at_end) begin
               total_ff   <= total_fin;
               outcome_ff <= tkp_pkg::OUT_CTL;
            end
         end
         tkp_pkg::ST_DUMP: begin
            if (load_entry) sent_ff <= sent_ff + TW'(1);
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_entry || load_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_entry) begin
         rsp_ff <= '{outcome: tkp_pkg::OUT_CTL, entry_valid: 1'b1,
                     entry_probe: head.key[24], entry_phase: head.key[23:16],
                     entry_group: head.key[15:0], entry_line: head.line,
                     entry_calls: head.calls, entry_cycles: head.cycles,
                     last: (sent_ff + TW'(1) == total_ff)};
      end else if (load_final) begin
         rsp_ff <= '{outcome: outcome_ff, entry_valid: 1'b0, entry_probe: 1'b0,
                     entry_phase: '0, entry_group: '0, entry_line: '0,
                     entry_calls: '0, entry_cycles: '0, last: 1'b1};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkp_pkg::ST_IDLE) |-> (pos_ff == '0))
      else $error("ring not back in order when idle");

   a_sent_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkp_pkg::ST_DUMP) |-> (sent_ff <= total_ff))
      else $error("dump emitted more slots than counted");

   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (state_ff == tkp_pkg::ST_DUMP))
      else $error("non-final result outside a dump");

endmodule

### rtl/tkp_cell.sv
`timescale 1ns / 1ps

module tkp_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              clear,
   input  tkp_pkg::slot_type slot_in,
   output tkp_pkg::slot_type slot_out
);

   logic [31:0]               calls_ff;
   logic [tkp_pkg::KEY_W-1:0] key_ff;
   logic [31:0]               line_ff;
   logic [63:0]               cycles_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         calls_ff <= '0;
      end else if (shift_en) begin
         calls_ff <= slot_in.calls;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         key_ff    <= slot_in.key;
         line_ff   <= slot_in.line;
         cycles_ff <= slot_in.cycles;
      end
   end

   assign slot_out = '{key: key_ff, line: line_ff, calls: calls_ff, cycles: cycles_ff};

endmodule
